// ----- rtl/greedy_box_suppression_defines.svh -----
// Assertion macros shared by the suppression block RTL.
// No dependencies; included by modules that carry assertions.
`ifndef GREEDY_BOX_SUPPRESSION_DEFINES_SVH
`define GREEDY_BOX_SUPPRESSION_DEFINES_SVH

// Check on every rising clk_i edge, disabled while rst_ni is low.
`define GBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every rising clk_i edge, reset included.
`define GBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/gbs_pkg.sv -----
// Types, constants and the overlap helper of the box suppression block.
// No dependencies; imported by the top level.
package gbs_pkg;

  localparam int COORD_W = 16;
  localparam int EDGE_W  = 18;
  localparam int AREA_W  = 32;
  localparam int UNI_W   = 33;
  localparam int THR_W   = 9;
  localparam int SLOT_W  = 6;
  localparam int IDX_W   = 16;
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [THR_W-1:0] THR_RESET = 9'd102;
  localparam logic [IDX_W-1:0] IDX_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [AREA_W-1:0]         area;
    logic [COORD_W-1:0]        h;
    logic [COORD_W-1:0]        w;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } pick_t;

  localparam int PICK_W = $bits(pick_t);

  function automatic logic [COORD_W-1:0] overlap(
    input logic signed [EDGE_W-1:0] a0,
    input logic signed [EDGE_W-1:0] a1,
    input logic signed [EDGE_W-1:0] b0,
    input logic signed [EDGE_W-1:0] b1
  );
    logic signed [EDGE_W-1:0] lo;
    logic signed [EDGE_W-1:0] hi;
    logic signed [EDGE_W-1:0] diff;
    lo   = (a0 > b0) ? a0 : b0;
    hi   = (a1 < b1) ? a1 : b1;
    diff = hi - lo;
    return (diff > 0) ? diff[COORD_W-1:0] : '0;
  endfunction

endpackage

// ----- rtl/gbs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the stored picks of the suppression block.
module gbs_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/greedy_box_suppression.sv -----
// Greedy box suppression by IoU: top level, sequencer and shared multiplier.
// Depends on gbs_pkg, gbs_ram and greedy_box_suppression_defines.svh.
// The scan compares the box with the stored picks in order and stops at the first suppressing pick;
//   a new box is accepted only in idle, after the result of the previous box has been loaded for output.
// The rate is set by the one multiplier, used twice per stored pick, and one RAM read port.
// Reset clears the store count, item count and state and loads threshold 102; no clearing pass.
`include "greedy_box_suppression_defines.svh"

module greedy_box_suppression
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [THR_W-1:0]  cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,   // box_x, box_y, box_w, box_h
  input  logic [0:0]        s_axis_tuser,   // first
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // item_index, kept_slot, zero pad
  output logic [1:0]        m_axis_tuser    // keep, store_full
);

  localparam int CNT_W = $clog2(MAX_KEPT + 1);
  localparam int AW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AREA,
    ST_OVL,
    ST_MUL1,
    ST_UNI,
    ST_MUL2,
    ST_CMP,
    ST_DECIDE
  } state_e;

  state_e state_q;

  logic [THR_W-1:0]         thr_q;
  logic [CNT_W-1:0]         kept_count_q;
  logic [CNT_W-1:0]         k_q;
  logic [IDX_W-1:0]         item_count_q;
  logic signed [COORD_W-1:0] bx_q;
  logic signed [COORD_W-1:0] by_q;
  logic [COORD_W-1:0]       bw_q;
  logic [COORD_W-1:0]       bh_q;
  logic signed [EDGE_W-1:0] bx1_q;
  logic signed [EDGE_W-1:0] by1_q;
  logic [AREA_W-1:0]        area_q;
  logic [AREA_W-1:0]        parea_q;
  logic [COORD_W-1:0]       iw_q;
  logic [COORD_W-1:0]       ih_q;
  logic [AREA_W-1:0]        inter_q;
  logic [UNI_W-1:0]         uni_q;
  logic [PROD_W-1:0]        prod_q;
  logic                     keep_q;
  logic                     out_valid_q;
  logic [23:0]              out_data_q;
  logic [1:0]               out_user_q;

  logic                     in_acc;
  logic                     out_free;
  logic                     out_load;
  logic                     has_room;
  logic                     suppress;
  logic [CNT_W-1:0]         k_next;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic signed [EDGE_W-1:0] px0;
  logic signed [EDGE_W-1:0] px1;
  logic signed [EDGE_W-1:0] py0;
  logic signed [EDGE_W-1:0] py1;
  logic                     ram_we;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  pick_t                    ram_wdata;
  pick_t                    ram_rdata;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = (state_q == ST_DECIDE) && out_free;
  assign has_room = kept_count_q < CNT_W'(MAX_KEPT);
  assign k_next   = k_q + CNT_W'(1);
  assign suppress = (uni_q != '0) && ({9'd0, inter_q, 8'd0} > prod_q);

  assign px0 = {{2{ram_rdata.x[COORD_W-1]}}, ram_rdata.x};
  assign py0 = {{2{ram_rdata.y[COORD_W-1]}}, ram_rdata.y};
  assign px1 = px0 + $signed({2'b00, ram_rdata.w});
  assign py1 = py0 + $signed({2'b00, ram_rdata.h});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_AREA: begin
        mul_a = {17'd0, bw_q};
        mul_b = bh_q;
      end
      ST_MUL1: begin
        mul_a = {17'd0, iw_q};
        mul_b = ih_q;
      end
      ST_MUL2: begin
        mul_a = uni_q;
        mul_b = {7'd0, thr_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign ram_re    = (state_q == ST_AREA) || (state_q == ST_OVL);
  assign ram_raddr = (state_q == ST_OVL) ? k_next[AW-1:0] : '0;
  assign ram_we    = out_load && keep_q && has_room;
  assign ram_wdata = '{area: area_q, h: bh_q, w: bw_q, y: by_q, x: bx_q};

  gbs_ram #(
    .WIDTH (PICK_W),
    .DEPTH (MAX_KEPT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (kept_count_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      thr_q        <= THR_RESET;
      kept_count_q <= '0;
      item_count_q <= '0;
      k_q          <= '0;
      keep_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_user_q   <= '0;
      bx_q         <= '0;
      by_q         <= '0;
      bw_q         <= '0;
      bh_q         <= '0;
      bx1_q        <= '0;
      by1_q        <= '0;
      area_q       <= '0;
      parea_q      <= '0;
      iw_q         <= '0;
      ih_q         <= '0;
      inter_q      <= '0;
      uni_q        <= '0;
      prod_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            bx_q   <= s_axis_tdata[15:0];
            by_q   <= s_axis_tdata[31:16];
            bw_q   <= s_axis_tdata[47:32];
            bh_q   <= s_axis_tdata[63:48];
            bx1_q  <= $signed({{2{s_axis_tdata[15]}}, s_axis_tdata[15:0]})
                      + $signed({2'b00, s_axis_tdata[47:32]});
            by1_q  <= $signed({{2{s_axis_tdata[31]}}, s_axis_tdata[31:16]})
                      + $signed({2'b00, s_axis_tdata[63:48]});
            keep_q <= 1'b1;
            k_q    <= '0;
            if (s_axis_tuser[0]) begin
              kept_count_q <= '0;
              item_count_q <= '0;
            end
            state_q <= ST_AREA;
          end
        end
        ST_AREA: begin
          area_q  <= mul_p[AREA_W-1:0];
          state_q <= (kept_count_q == '0) ? ST_DECIDE : ST_OVL;
        end
        ST_OVL: begin
          iw_q    <= overlap(bx_q, bx1_q, px0, px1);
          ih_q    <= overlap(by_q, by1_q, py0, py1);
          parea_q <= ram_rdata.area;
          state_q <= ST_MUL1;
        end
        ST_MUL1: begin
          inter_q <= mul_p[AREA_W-1:0];
          state_q <= ST_UNI;
        end
        ST_UNI: begin
          uni_q   <= {1'b0, area_q} + {1'b0, parea_q} - {1'b0, inter_q};
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          prod_q  <= mul_p;
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          k_q <= k_next;
          if (suppress) begin
            keep_q  <= 1'b0;
            state_q <= ST_DECIDE;
          end else if (k_next == kept_count_q) begin
            state_q <= ST_DECIDE;
          end else begin
            state_q <= ST_OVL;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            out_data_q  <= {2'b00,
                            (keep_q && has_room) ? SLOT_W'(kept_count_q) : {SLOT_W{1'b0}},
                            item_count_q};
            out_user_q  <= {keep_q && !has_room, keep_q};
            if (keep_q && has_room) begin
              kept_count_q <= kept_count_q + CNT_W'(1);
            end
            if (item_count_q != IDX_MAX) begin
              item_count_q <= item_count_q + IDX_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `GBS_ASSERT(a_count_bound, kept_count_q <= CNT_W'(MAX_KEPT), "store count past depth")
  `GBS_ASSERT(a_out_from_decide, $rose(out_valid_q) |-> $past(state_q == ST_DECIDE),
              "result raised outside decide")
  `GBS_ASSERT(a_scan_in_range, (state_q == ST_OVL) |-> (k_q < kept_count_q),
              "scan index past stored picks")
  `GBS_ASSERT(a_accept_starts, in_acc |=> (state_q == ST_AREA), "accept did not start area")

endmodule

// ----- tb/greedy_box_suppression_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for greedy_box_suppression: a directed table, random box sets, a long hold.
// Depends on gbs_pkg and the block RTL; every result word is checked against the table or a local predictor.

module greedy_box_suppression_test;
  import gbs_pkg::*;

  localparam int MAX_PICKS    = 64;
  localparam int HOLD_CYCLES  = 600;
  localparam int TAIL_CYCLES  = 400;
  localparam int REPORT_LIMIT = 10;
  localparam longint CYCLE_LIMIT = 5_000_000;

  typedef enum logic {ROW_BOX, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic              keep;
    logic [IDX_W-1:0]  index;
    logic [SLOT_W-1:0] slot;
    logic              full;
  } verdict_t;

  typedef struct {
    row_kind_e          kind;
    logic               first;
    logic [COORD_W-1:0] x, y, w, h;
    logic [THR_W-1:0]   thr;
    logic               typed;
    verdict_t           want;
  } row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [THR_W-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata  = '0;  // box_x, box_y, box_w, box_h
  logic [0:0]        s_axis_tuser  = '0;  // first
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;        // item_index, kept_slot, zero pad
  logic [1:0]        m_axis_tuser;        // keep, store_full

  longint           pick_x0 [MAX_PICKS];
  longint           pick_y0 [MAX_PICKS];
  longint           pick_x1 [MAX_PICKS];
  longint           pick_y1 [MAX_PICKS];
  longint           pick_area [MAX_PICKS];
  int               picks_held = 0;
  int               boxes_seen = 0;
  logic [THR_W-1:0] iou_thr    = THR_RESET;

  verdict_t verdicts [$];
  verdict_t seen_word;
  verdict_t due_word;

  int     fault_count      = 0;
  int     boxes_total      = 0;
  int     sets_total       = 0;
  int     kept_total       = 0;
  int     full_total       = 0;
  int     suppressed_total = 0;
  int     tx_idle_pct      = 0;
  int     rx_idle_pct      = 0;
  int     stall_req        = 0;
  int     stall_seen       = 0;
  int     stall_left       = 0;
  longint cycles           = 0;

  row_t plan [22] = '{
    '{ROW_BOX, 1'b1, 16'h0000, 16'h0000, 16'h00A0, 16'h00A0, 9'd0, 1'b1,
      '{1'b1, 16'd0, 6'd0, 1'b0}},
    '{ROW_BOX, 1'b0, 16'h0000, 16'h0000, 16'h00A0, 16'h00A0, 9'd0, 1'b1,
      '{1'b0, 16'd1, 6'd0, 1'b0}},
    '{ROW_BOX, 1'b0, 16'h00A0, 16'h0000, 16'h00A0, 16'h00A0, 9'd0, 1'b1,
      '{1'b1, 16'd2, 6'd1, 1'b0}},
    '{ROW_BOX, 1'b0, 16'h000A, 16'h000A, 16'h0000, 16'h0000, 9'd0, 1'b1,
      '{1'b1, 16'd3, 6'd2, 1'b0}},
    '{ROW_BOX, 1'b0, 16'h000A, 16'h000A, 16'h0000, 16'h0000, 9'd0, 1'b1,
      '{1'b1, 16'd4, 6'd3, 1'b0}},
    '{ROW_BOX, 1'b0, 16'h0050, 16'h0000, 16'h00A0, 16'h00A0, 9'd0, 1'b0, '0},
    '{ROW_BOX, 1'b0, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 9'd0, 1'b0, '0},
    '{ROW_BOX, 1'b0, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 9'd0, 1'b0, '0},
    '{ROW_BOX, 1'b0, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 9'd0, 1'b0, '0},
    '{ROW_CFG, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 9'd0, 1'b0, '0},
    '{ROW_BOX, 1'b1, 16'h0000, 16'h0000, 16'h0010, 16'h0010, 9'd0, 1'b1,
      '{1'b1, 16'd0, 6'd0, 1'b0}},
    '{ROW_BOX, 1'b0, 16'h000F, 16'h000F, 16'h0010, 16'h0010, 9'd0, 1'b0, '0},
    '{ROW_BOX, 1'b0, 16'h0010, 16'h0000, 16'h0010, 16'h0010, 9'd0, 1'b0, '0},
    '{ROW_CFG, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 9'd256, 1'b0, '0},
    '{ROW_BOX, 1'b1, 16'h0000, 16'h0000, 16'h0010, 16'h0010, 9'd0, 1'b1,
      '{1'b1, 16'd0, 6'd0, 1'b0}},
    '{ROW_BOX, 1'b0, 16'h0000, 16'h0000, 16'h0010, 16'h0010, 9'd0, 1'b1,
      '{1'b1, 16'd1, 6'd1, 1'b0}},
    '{ROW_CFG, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 9'd511, 1'b0, '0},
    '{ROW_BOX, 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 9'd0, 1'b1,
      '{1'b1, 16'd0, 6'd0, 1'b0}},
    '{ROW_BOX, 1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 9'd0, 1'b1,
      '{1'b1, 16'd1, 6'd1, 1'b0}},
    '{ROW_CFG, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 9'd102, 1'b0, '0},
    '{ROW_BOX, 1'b0, 16'h8000, 16'h8000, 16'hFFFF, 16'h0000, 9'd0, 1'b0, '0},
    '{ROW_BOX, 1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 9'd0, 1'b0, '0}
  };

  greedy_box_suppression #(
    .MAX_KEPT(MAX_PICKS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint span(input longint a0, a1, b0, b1);
    longint lo;
    longint hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function automatic verdict_t judge_box(input logic first,
                                         input logic [COORD_W-1:0] x, y, w, h);
    longint   bx0, by0, bx1, by1, area, inter, uni;
    int       k;
    verdict_t v;
    v = '0;
    v.keep = 1'b1;
    if (first) begin
      picks_held = 0;
      boxes_seen = 0;
    end
    bx0  = longint'($signed(x));
    by0  = longint'($signed(y));
    bx1  = bx0 + longint'(w);
    by1  = by0 + longint'(h);
    area = longint'(w) * longint'(h);
    for (k = 0; k < picks_held; k++) begin
      inter = span(bx0, bx1, pick_x0[k], pick_x1[k]) * span(by0, by1, pick_y0[k], pick_y1[k]);
      uni   = area + pick_area[k] - inter;
      if (uni != 0 && inter * 256 > longint'(iou_thr) * uni) v.keep = 1'b0;
    end
    if (v.keep) begin
      if (picks_held < MAX_PICKS) begin
        v.slot = picks_held[SLOT_W-1:0];
        pick_x0[picks_held]   = bx0;
        pick_y0[picks_held]   = by0;
        pick_x1[picks_held]   = bx1;
        pick_y1[picks_held]   = by1;
        pick_area[picks_held] = area;
        picks_held++;
      end else begin
        v.full = 1'b1;
      end
    end
    v.index = boxes_seen[IDX_W-1:0];
    if (boxes_seen < 65535) boxes_seen++;
    return v;
  endfunction

  task automatic offer_box(input logic first, input logic [COORD_W-1:0] x, y, w, h,
                           input logic typed, input verdict_t want);
    verdict_t v;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= first;
    s_axis_tdata  <= {h, w, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    v = judge_box(first, x, y, w, h);
    verdicts.insert(verdicts.size(), typed ? want : v);
    boxes_total++;
    if (first) sets_total++;
    if (!v.keep) suppressed_total++;
    else if (v.full) full_total++;
    else kept_total++;
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    iou_thr = value;
  endtask

  task automatic run_mix(input int budget);
    int                 sent, n, k, pick, s, cx, cy, t;
    logic [31:0]        r;
    logic [COORD_W-1:0] x, y, w, h;
    logic               filled;
    sent   = 0;
    filled = 1'b0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 12 && !filled) begin
        filled = 1'b1;
        n = MAX_PICKS + $urandom_range(8, 2);
        for (k = 0; k < n; k++) begin
          if (k < MAX_PICKS) begin
            cx = k % 8;
            cy = k / 8;
            t  = 0;
          end else begin
            cx = $urandom_range(7);
            cy = $urandom_range(7);
            t  = ($urandom_range(1) == 1) ? 4096 : 0;
          end
          cx = -32768 + cx * 8192 + t + $urandom_range(2047);
          cy = -32768 + cy * 8192 + t + $urandom_range(2047);
          r  = $urandom;
          x  = cx[15:0];
          y  = cy[15:0];
          w  = {5'd0, r[10:0]};
          h  = {5'd0, r[26:16]};
          offer_box(k == 0, x, y, w, h, 1'b0, '0);
        end
        sent += n;
      end else if (pick < 90) begin
        n  = $urandom_range(24, 1);
        s  = 1 << $urandom_range(16, 2);
        cx = $urandom_range(65535);
        cy = $urandom_range(65535);
        for (k = 0; k < n; k++) begin
          t = cx + $urandom_range(s / 2) - s / 4;
          x = t[15:0];
          t = cy + $urandom_range(s / 2) - s / 4;
          y = t[15:0];
          t = $urandom_range(s - 1, s / 4);
          w = t[15:0];
          t = $urandom_range(s - 1, s / 4);
          h = t[15:0];
          offer_box(k == 0, x, y, w, h, 1'b0, '0);
        end
        sent += n;
      end else begin
        r = $urandom;
        x = r[15:0];
        y = r[31:16];
        r = $urandom;
        w = r[15:0];
        h = r[31:16];
        offer_box($urandom_range(1) == 1, x, y, w, h, 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_seen != stall_req) begin
      stall_seen    <= stall_req;
      stall_left    <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_word = {m_axis_tuser[0], m_axis_tdata[15:0], m_axis_tdata[21:16], m_axis_tuser[1]};
      if (verdicts.size() == 0) begin
        if (fault_count < REPORT_LIMIT) begin
          $display("unexpected result word: keep %0b index %0d slot %0d full %0b",
                   seen_word.keep, seen_word.index, seen_word.slot, seen_word.full);
        end
        fault_count++;
      end else begin
        due_word = verdicts.pop_front();
        if (seen_word !== due_word) begin
          if (fault_count < REPORT_LIMIT) begin
            $display("mismatch: keep %0b/%0b index %0d/%0d slot %0d/%0d full %0b/%0b (exp/act)",
                     due_word.keep, seen_word.keep, due_word.index, seen_word.index,
                     due_word.slot, seen_word.slot, due_word.full, seen_word.full);
          end
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, verdicts.size());
      $display("greedy_box_suppression_test NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] r;
    tx_idle_pct = 6;
    rx_idle_pct = 82;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_threshold(plan[i].thr);
      end else begin
        offer_box(plan[i].first, plan[i].x, plan[i].y, plan[i].w, plan[i].h,
                  plan[i].typed, plan[i].want);
      end
    end

    r = $urandom_range(200, 40);
    write_threshold(r[8:0]);
    run_mix(340);

    r = $urandom_range(256, 0);
    write_threshold(r[8:0]);
    tx_idle_pct = 82;
    rx_idle_pct = 6;
    run_mix(340);

    r = $urandom_range(511, 0);
    write_threshold(r[8:0]);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    stall_req <= stall_req + 1;
    run_mix(340);

    write_threshold(THR_RESET);

    s_axis_tvalid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d boxes in %0d sets: %0d stored, %0d suppressed, %0d with the store full",
             boxes_total, sets_total, kept_total, suppressed_total, full_total);
    $display("thresholds 0 to 511, output held off for %0d cycles", HOLD_CYCLES);
    if (fault_count == 0) begin
      $display("greedy_box_suppression_test OK");
    end else begin
      $display("%0d result words failed", fault_count);
      $display("greedy_box_suppression_test NOT OK");
    end
    $finish;
  end

endmodule
